### rtl/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared constants for the vector normalize pipeline.
// ----------------------------------------------------------------------------
package vnorm_pkg;

	// result field width and fraction bits of the Q1.15 unit components
	localparam int OUT_W     = 16;
	localparam int FRAC_BITS = 15;
	localparam int Q_W       = FRAC_BITS + 1;

	localparam logic [OUT_W-1:0] UNIT_MAX_POS = 16'h7FFF;

endpackage

### rtl/vector3_normalize_unit.sv
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// Magnitude and unit vector of a signed Q8.8 3D vector.
// ----------------------------------------------------------------------------
// One vector is taken in every cycle (busy stays low) and its result leaves
// as a one-cycle done strobe after the squaring and summing stages, the
// square-root pipeline, sixteen divider stages (one per quotient bit) and an
// output register. The receiver cannot stall, so results must be taken when
// done is high. A zero vector returns zero length and components with
// zero_vector set.
module vector3_normalize_unit import vnorm_pkg::*; #(
	parameter int COMP_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COMP_WIDTH-1:0] comp_x,
	input  logic [COMP_WIDTH-1:0] comp_y,
	input  logic [COMP_WIDTH-1:0] comp_z,
	output logic                  done,
	output logic [OUT_W-1:0]      length,
	output logic [OUT_W-1:0]      unit_x,
	output logic [OUT_W-1:0]      unit_y,
	output logic [OUT_W-1:0]      unit_z,
	output logic                  zero_vector
);

	localparam int W      = COMP_WIDTH;
	localparam int SIDE_W = 3 * (W + 1);

	logic               sq_valid, rt_valid, dv_valid;
	logic [2*W-1:0]     sum_sq;
	logic [SIDE_W-1:0]  sq_side, rt_side;
	logic [W-1:0]       mag, mag_out, mag_y, mag_z;
	logic               dvy_valid, dvz_valid;
	logic [OUT_W-1:0]   ux, uy, uz;
	logic [W+OUT_W-1:0] mag_ext;
	logic               zero_mag;

	logic               done_q, zero_q;
	logic [OUT_W-1:0]   length_q, ux_q, uy_q, uz_q;

	assign busy = 1'b0;

	vnorm_square #(.W(W)) u_square (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
		.out_valid(sq_valid), .sum_sq(sum_sq), .side(sq_side)
	);

	vnorm_sqrt #(.W(W), .SIDE_W(SIDE_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_valid),
		.radicand(sum_sq), .side_in(sq_side),
		.out_valid(rt_valid), .root(mag), .side_out(rt_side)
	);

	// side layout: {neg_x, |x|, neg_y, |y|, neg_z, |z|}
	vnorm_div #(.W(W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .in_valid(rt_valid),
		.neg(rt_side[3*W+2]), .num(rt_side[3*W+1 -: W]), .den(mag),
		.out_valid(dv_valid), .unit(ux), .den_out(mag_out)
	);

	vnorm_div #(.W(W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .in_valid(rt_valid),
		.neg(rt_side[2*W+1]), .num(rt_side[2*W -: W]), .den(mag),
		.out_valid(dvy_valid), .unit(uy), .den_out(mag_y)
	);

	vnorm_div #(.W(W)) u_div_z (
		.clk(clk), .arst_n(arst_n), .in_valid(rt_valid),
		.neg(rt_side[W]), .num(rt_side[W-1:0]), .den(mag),
		.out_valid(dvz_valid), .unit(uz), .den_out(mag_z)
	);

	assign mag_ext  = {{OUT_W{1'b0}}, mag_out};
	assign zero_mag = (mag_out == '0);

	// hold the done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	// register the result beat, forcing zeros for a zero vector
	always_ff @(posedge clk) begin
		zero_q   <= zero_mag;
		length_q <= mag_ext[OUT_W-1:0];
		ux_q     <= zero_mag ? '0 : ux;
		uy_q     <= zero_mag ? '0 : uy;
		uz_q     <= zero_mag ? '0 : uz;
	end

	assign done        = done_q;
	assign zero_vector = zero_q;
	assign length      = length_q;
	assign unit_x      = ux_q;
	assign unit_y      = uy_q;
	assign unit_z      = uz_q;

	// the three divider lanes move in lockstep
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_valid == dvy_valid) && (dv_valid == dvz_valid))
		else $error("divider lanes out of step");

	// a zero vector beat carries zero length and components
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_vector) |-> (length == '0 && unit_x == '0 &&
		unit_y == '0 && unit_z == '0))
		else $error("zero vector result not cleared");

	// all divider lanes carry the same magnitude for a valid beat
	a_lanes_same_mag: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid |-> (mag_out == mag_y && mag_out == mag_z))
		else $error("divider lanes carry different magnitudes");

endmodule

### rtl/vnorm_square.sv
// ----------------------------------------------------------------------------
// vnorm_square
// Two-stage front end: squares and magnitudes, then the sum of squares.
// ----------------------------------------------------------------------------
module vnorm_square import vnorm_pkg::*; #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [W-1:0]         comp_x,
	input  logic [W-1:0]         comp_y,
	input  logic [W-1:0]         comp_z,
	output logic                 out_valid,
	output logic [2*W-1:0]       sum_sq,
	output logic [3*(W+1)-1:0]   side
);

	logic               valid_s1, valid_s2;
	logic [2*W-1:0]     sqx_s1, sqy_s1, sqz_s1;
	logic [3*(W+1)-1:0] side_s1, side_s2;
	logic [2*W-1:0]     sum_s2;
	logic [W-1:0]       ax, ay, az;

	// magnitudes of the components
	assign ax = comp_x[W-1] ? (~comp_x + 1'b1) : comp_x;
	assign ay = comp_y[W-1] ? (~comp_y + 1'b1) : comp_y;
	assign az = comp_z[W-1] ? (~comp_z + 1'b1) : comp_z;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// square, then sum
	always_ff @(posedge clk) begin
		sqx_s1  <= ax * ax;
		sqy_s1  <= ay * ay;
		sqz_s1  <= az * az;
		side_s1 <= {comp_x[W-1], ax, comp_y[W-1], ay, comp_z[W-1], az};
		sum_s2  <= sqx_s1 + sqy_s1 + sqz_s1;
		side_s2 <= side_s1;
	end

	assign out_valid = valid_s2;
	assign sum_sq    = sum_s2;
	assign side      = side_s2;

endmodule

### rtl/vnorm_sqrt.sv
// ----------------------------------------------------------------------------
// vnorm_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vnorm_sqrt import vnorm_pkg::*; #(
	parameter int W      = 16,
	parameter int SIDE_W = 51
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*W-1:0]    radicand,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [W-1:0]      root,
	output logic [SIDE_W-1:0] side_out
);

	logic              valid_s [W+1];
	logic [W:0]        rem_s   [W+1];
	logic [W-1:0]      root_s  [W+1];
	logic [2*W-1:0]    rad_s   [W+1];
	logic [SIDE_W-1:0] side_s  [W+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign rad_s[0]   = radicand;
	assign side_s[0]  = side_in;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W+2:0] cur;
		logic [W+2:0] trial;
		logic         fit;

		// bring down two radicand bits and try the next root bit
		assign cur   = {rem_s[i], rad_s[i][2*W-1 -: 2]};
		assign trial = {1'b0, root_s[i], 2'b01};
		assign fit   = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		// the remainder can reach twice the root, so keep all W+1 bits
		always_ff @(posedge clk) begin
			rem_s[i+1]  <= fit ? (W+1)'(cur - trial) : cur[W:0];
			root_s[i+1] <= {root_s[i][W-2:0], fit};
			rad_s[i+1]  <= {rad_s[i][2*W-3:0], 2'b00};
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_valid = valid_s[W];
	assign root      = root_s[W];
	assign side_out  = side_s[W];

endmodule

### rtl/vnorm_div.sv
// ----------------------------------------------------------------------------
// vnorm_div
// Pipelined fractional divider: floor(num * 2^15 / den) for num <= den,
// one quotient bit per stage, with Q1.15 saturation at the end.
// ----------------------------------------------------------------------------
module vnorm_div import vnorm_pkg::*; #(
	parameter int W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             neg,
	input  logic [W-1:0]     num,
	input  logic [W-1:0]     den,
	output logic             out_valid,
	output logic [OUT_W-1:0] unit,
	output logic [W-1:0]     den_out
);

	logic           valid_s [Q_W+1];
	logic [W-1:0]   rem_s   [Q_W+1];
	logic [Q_W-1:0] quo_s   [Q_W+1];
	logic [W-1:0]   den_s   [Q_W+1];
	logic           neg_s   [Q_W+1];
	logic [Q_W-1:0] q;

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = num;
	assign quo_s[0]   = '0;
	assign den_s[0]   = den;
	assign neg_s[0]   = neg;

	for (genvar j = 0; j < Q_W; j++) begin : g_stage
		logic [W:0] cur;
		logic       fit;

		// first step compares the numerator itself, later ones the doubled rest
		if (j == 0) begin : g_first
			assign cur = {1'b0, rem_s[j]};
		end else begin : g_next
			assign cur = {rem_s[j], 1'b0};
		end
		assign fit = (cur >= {1'b0, den_s[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= fit ? W'(cur - {1'b0, den_s[j]}) : cur[W-1:0];
			quo_s[j+1] <= {quo_s[j][Q_W-2:0], fit};
			den_s[j+1] <= den_s[j];
			neg_s[j+1] <= neg_s[j];
		end
	end

	// saturate +1.0, negate for negative components
	assign q = quo_s[Q_W];
	always_comb begin
		if (neg_s[Q_W]) begin
			unit = OUT_W'(~q + 1'b1);
		end else if (q[Q_W-1]) begin
			unit = UNIT_MAX_POS;
		end else begin
			unit = OUT_W'(q);
		end
	end

	assign out_valid = valid_s[Q_W];
	assign den_out   = den_s[Q_W];

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the vector normalize unit: directed corner vectors, then random
// vectors under three idling patterns, each result compared with a predicted
// magnitude and unit vector computed here.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CW        = 16;
	localparam int LATENCY   = CW + 19;
	localparam int MAX_CYC   = 200000;
	localparam logic [15:0] Q_ONE = 16'h8000;

	typedef struct packed {
		logic [15:0] len;
		logic [15:0] ux;
		logic [15:0] uy;
		logic [15:0] uz;
		logic        zf;
	} norm_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic [CW-1:0] comp_x = '0;
	logic [CW-1:0] comp_y = '0;
	logic [CW-1:0] comp_z = '0;
	logic          done;
	logic [15:0]   length, unit_x, unit_y, unit_z;
	logic          zero_vector;

	norm_t norm_q[$];
	int    n_bad = 0;
	int    cyc = 0;
	int    idle_pct = 0;

	vector3_normalize_unit #(.COMP_WIDTH(CW)) dut (.*);

	always #4 clk = ~clk;

	// floor square root, digit by digit
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// scale one component to Q1.15 with saturation at +1.0
	function automatic logic [15:0] unit_comp(longint c, longint unsigned mag);
		longint unsigned q, a;
		a = (c < 0) ? -c : c;
		q = (a * Q_ONE) / mag;
		if (c < 0) begin
			if (q > Q_ONE) q = Q_ONE;
			return 16'(-longint'(q));
		end
		if (q > Q_ONE - 1) q = Q_ONE - 1;
		return 16'(q);
	endfunction

	function automatic norm_t normalize(logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, logic signed [CW-1:0] z);
		norm_t r;
		longint xs, ys, zs;
		longint unsigned mag;
		xs = x;
		ys = y;
		zs = z;
		mag = root_floor(xs * xs + ys * ys + zs * zs);
		r = '0;
		if (mag == 0) begin
			r.zf = 1'b1;
			return r;
		end
		r.len = 16'(mag);
		r.ux = unit_comp(xs, mag);
		r.uy = unit_comp(ys, mag);
		r.uz = unit_comp(zs, mag);
		return r;
	endfunction

	// watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > MAX_CYC) begin
			$display("tb: failure");
			$finish;
		end
	end

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		norm_t got, want;
		if (arst_n && done) begin
			got = '{length, unit_x, unit_y, unit_z, zero_vector};
			if (norm_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result %h", got);
			end else begin
				want = norm_q.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch exp len %h u %h %h %h z %b got len %h u %h %h %h z %b",
							want.len, want.ux, want.uy, want.uz, want.zf,
							got.len, got.ux, got.uy, got.uz, got.zf);
				end
			end
		end
	end

	// send one vector beat, with random idle cycles before it
	task automatic send_vec(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start  <= 1'b1;
		comp_x <= x;
		comp_y <= y;
		comp_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		norm_q.push_back(normalize(x, y, z));
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (norm_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_corners();
		send_vec(0, 0, 0);
		send_vec(16'h7FFF, 0, 0);
		send_vec(16'h8000, 0, 0);
		send_vec(0, 16'h8000, 0);
		send_vec(0, 0, 16'h7FFF);
		send_vec(0, 0, 16'h8000);
		send_vec(16'h8000, 16'h8000, 16'h8000);
		send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_vec(16'h7FFF, 16'h8000, 16'h7FFF);
		send_vec(1, 0, 0);
		send_vec(16'hFFFF, 0, 0);
		send_vec(1, 1, 1);
		send_vec(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_vec(3, 4, 0);
		send_vec(16'hFD00, 16'h0400, 0);
		send_vec(16'h0100, 16'h0200, 16'h0200);
		send_vec(16'h5555, 16'hAAAA, 16'h0F0F);
		drain();
	endtask

	// half full-range vectors, a quarter small and a quarter 2D
	task automatic test_random(int n);
		logic [CW-1:0] x, y, z;
		for (int i = 0; i < n; i++) begin
			x = CW'($urandom);
			y = CW'($urandom);
			z = CW'($urandom);
			case ($urandom_range(3))
				0: begin
					x = CW'($urandom_range(7) - 4);
					y = CW'($urandom_range(7) - 4);
					z = CW'($urandom_range(7) - 4);
				end
				1: z = '0;
				default: ;
			endcase
			send_vec(x, y, z);
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		idle_pct = 11;
		test_random(350);
		idle_pct = 61;
		test_random(350);
		idle_pct = 0;
		test_random(350);
		repeat (LATENCY + 5) @(posedge clk);
		if (n_bad == 0 && norm_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/vnorm_pkg.sv
rtl/vnorm_square.sv
rtl/vnorm_sqrt.sv
rtl/vnorm_div.sv
rtl/vector3_normalize_unit.sv
tb/tb_top.sv
